>>> src/dq_pkg.sv
package dq_pkg;

   localparam int DEPTH = 1024;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int WORD_W = 32;
   localparam int OP_W = 3;
   localparam int COUNT_OUT_W = 11;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_REPORT     = 3'd4;

   typedef struct packed {
      logic accept;
      logic finish;
   } dq_cmd_type;

   // (base + off) mod DEPTH, base < DEPTH and off <= DEPTH
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

>>> src/dq_if.sv
interface dq_req_if;
   logic                               valid;
   logic                               ready;
   logic [dq_pkg::OP_W-1:0]            op;
   logic signed [dq_pkg::WORD_W-1:0]   push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink (input valid, input op, input push_value, output ready);
endinterface

interface dq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [dq_pkg::WORD_W-1:0]   popped_value;
   logic                               popped_valid;
   logic [dq_pkg::COUNT_OUT_W-1:0]     entry_count;
   logic                               is_empty;
   logic signed [dq_pkg::WORD_W-1:0]   front_value;
   logic signed [dq_pkg::WORD_W-1:0]   back_value;
   logic                               overflow;

   modport source (output valid, output popped_value, output popped_valid,
                   output entry_count, output is_empty, output front_value,
                   output back_value, output overflow, input ready);
   modport sink (input valid, input popped_value, input popped_valid,
                 input entry_count, input is_empty, input front_value,
                 input back_value, input overflow, output ready);
endinterface

>>> src/dq_ram.sv
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/dq_ctrl.sv
module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dq_pkg::dq_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      cmd.accept = req_valid && req_ready;
      // result lands in the output register once it is free
      cmd.finish = (state_ff == S_READ) && (!rsp_valid_ff || rsp_ready);

      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (cmd.finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/dq_datapath.sv
module dq_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dq_pkg::dq_cmd_type                    cmd,
   input  logic [dq_pkg::OP_W-1:0]               req_op,
   input  logic signed [dq_pkg::WORD_W-1:0]      req_push_value,
   output logic signed [dq_pkg::WORD_W-1:0]      rsp_popped_value,
   output logic                                  rsp_popped_valid,
   output logic [dq_pkg::COUNT_OUT_W-1:0]        rsp_entry_count,
   output logic                                  rsp_is_empty,
   output logic signed [dq_pkg::WORD_W-1:0]      rsp_front_value,
   output logic signed [dq_pkg::WORD_W-1:0]      rsp_back_value,
   output logic                                  rsp_overflow
);

   logic [dq_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [dq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [dq_pkg::WORD_W-1:0] front_ff, front_in;
   logic [dq_pkg::WORD_W-1:0] back_ff, back_in;
   logic [dq_pkg::WORD_W-1:0] pend_pop_ff, pend_pop_in;
   logic                      pend_pvalid_ff, pend_pvalid_in;
   logic                      pend_ovf_ff, pend_ovf_in;
   logic                      ref_front_ff, ref_front_in;
   logic                      ref_back_ff, ref_back_in;

   logic signed [dq_pkg::WORD_W-1:0] out_pop_ff, out_front_ff, out_back_ff;
   logic [dq_pkg::COUNT_OUT_W-1:0]   out_count_ff;
   logic                             out_pvalid_ff, out_empty_ff, out_ovf_ff;

   logic                      wr_en, rd_en;
   logic [dq_pkg::IDX_W-1:0]  wr_addr, rd_addr;
   logic [dq_pkg::WORD_W-1:0] rd_data;
   logic [dq_pkg::IDX_W-1:0]  head_inc, head_dec;
   logic                      full, empty_now;

   dq_ram #(
      .WIDTH(dq_pkg::WORD_W),
      .DEPTH(dq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      head_inc = (head_ff == dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)) ? '0 : head_ff + 1'b1;
      head_dec = (head_ff == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1) : head_ff - 1'b1;
      full      = (count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
      empty_now = (count_ff == '0);

      head_in        = head_ff;
      count_in       = count_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      pend_pop_in    = pend_pop_ff;
      pend_pvalid_in = pend_pvalid_ff;
      pend_ovf_in    = pend_ovf_ff;
      ref_front_in   = ref_front_ff;
      ref_back_in    = ref_back_ff;
      wr_en          = 1'b0;
      wr_addr        = head_dec;
      rd_en          = 1'b0;
      rd_addr        = head_inc;

      priority if (cmd.accept) begin
         pend_pop_in    = '0;
         pend_pvalid_in = 1'b0;
         pend_ovf_in    = 1'b0;
         ref_front_in   = 1'b0;
         ref_back_in    = 1'b0;
         unique case (req_op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  pend_ovf_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (req_op == dq_pkg::OP_PUSH_FRONT) begin
                     wr_addr  = head_dec;
                     head_in  = head_dec;
                     front_in = req_push_value;
                     if (empty_now) begin
                        back_in = req_push_value;
                     end
                  end else begin
                     wr_addr = dq_pkg::wrap_add(head_ff, count_ff);
                     back_in = req_push_value;
                     if (empty_now) begin
                        front_in = req_push_value;
                     end
                  end
               end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
               if (!empty_now) begin
                  pend_pvalid_in = 1'b1;
                  count_in       = count_ff - 1'b1;
                  // refetch the new end word when something is left behind
                  if (req_op == dq_pkg::OP_POP_FRONT) begin
                     pend_pop_in  = front_ff;
                     head_in      = head_inc;
                     rd_addr      = head_inc;
                     rd_en        = (count_ff != dq_pkg::CNT_W'(1));
                     ref_front_in = rd_en;
                  end else begin
                     pend_pop_in = back_ff;
                     rd_addr     = dq_pkg::wrap_add(head_ff, count_ff - dq_pkg::CNT_W'(2));
                     rd_en       = (count_ff != dq_pkg::CNT_W'(1));
                     ref_back_in = rd_en;
                  end
               end
            end
            default: begin
               // report only, unused codes too
            end
         endcase
      end else if (cmd.finish) begin
         if (ref_front_ff) begin
            front_in = rd_data;
         end
         if (ref_back_ff) begin
            back_in = rd_data;
         end
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff       <= front_in;
      back_ff        <= back_in;
      pend_pop_ff    <= pend_pop_in;
      pend_pvalid_ff <= pend_pvalid_in;
      pend_ovf_ff    <= pend_ovf_in;
      ref_front_ff   <= ref_front_in;
      ref_back_ff    <= ref_back_in;
      if (cmd.finish) begin
         out_pop_ff    <= pend_pop_ff;
         out_pvalid_ff <= pend_pvalid_ff;
         out_ovf_ff    <= pend_ovf_ff;
         out_count_ff  <= dq_pkg::COUNT_OUT_W'(count_ff);
         out_empty_ff  <= empty_now;
         out_front_ff  <= empty_now ? '0 : front_in;
         out_back_ff   <= empty_now ? '0 : back_in;
      end
   end

   assign rsp_popped_value = out_pop_ff;
   assign rsp_popped_valid = out_pvalid_ff;
   assign rsp_entry_count  = out_count_ff;
   assign rsp_is_empty     = out_empty_ff;
   assign rsp_front_value  = out_front_ff;
   assign rsp_back_value   = out_back_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

>>> src/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words in a 1024-entry circular
// store. Each request word pushes at the front or back, pops from the front or
// back, or only reports; each gives exactly one response word with the popped
// word, the count, an empty flag, the front and back words and an overflow flag
// for a dropped push. A request has an accept step, which updates pointers and
// writes or reads the store (one write port, one read port), and a finish step,
// which takes the registered read data that refreshes the front or back word.
// A new request is taken once the previous one finishes, even while its response
// waits in the output register; a response still not taken stalls the next one.
module double_ended_queue (
   input logic      clock,
   input logic      reset,
   dq_req_if.sink   req,
   dq_rsp_if.source rsp
);

   dq_pkg::dq_cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   dq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_op           (req.op),
      .req_push_value   (req.push_value),
      .rsp_popped_value (rsp.popped_value),
      .rsp_popped_valid (rsp.popped_valid),
      .rsp_entry_count  (rsp.entry_count),
      .rsp_is_empty     (rsp.is_empty),
      .rsp_front_value  (rsp.front_value),
      .rsp_back_value   (rsp.back_value),
      .rsp_overflow     (rsp.overflow)
   );

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req.ready)
      else $error("request taken while previous one still in flight");

   a_no_double_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.finish))
      else $error("accept and finish in one cycle");

   a_empty_matches: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
      else $error("empty flag disagrees with count");

   a_pop_or_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.popped_valid && rsp.overflow))
      else $error("pop and overflow flagged together");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [dq_pkg::WORD_W-1:0]  popped_value;
      logic                              popped_valid;
      logic [dq_pkg::COUNT_OUT_W-1:0]    entry_count;
      logic                              is_empty;
      logic signed [dq_pkg::WORD_W-1:0]  front_value;
      logic signed [dq_pkg::WORD_W-1:0]  back_value;
      logic                              overflow;
   } deque_result_type;

   class deque_tracker_type;
      logic signed [dq_pkg::WORD_W-1:0] words [0:dq_pkg::DEPTH-1];
      int unsigned head;
      int unsigned count;
      deque_result_type pending_results[$];
      int mismatches;
      int results_seen;
      int overflows;
      int empty_pops;
      int peak;

      function new();
         head = 0;
         count = 0;
         mismatches = 0;
         results_seen = 0;
         overflows = 0;
         empty_pops = 0;
         peak = 0;
      endfunction

      // apply one accepted request word and queue the response it must give
      function void apply_op(logic [dq_pkg::OP_W-1:0] op,
                             logic signed [dq_pkg::WORD_W-1:0] value);
         deque_result_type r;
         r = '0;
         unique case (op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
               if (count >= dq_pkg::DEPTH) begin
                  r.overflow = 1'b1;
                  overflows++;
               end else if (op == dq_pkg::OP_PUSH_FRONT) begin
                  head = (head + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
                  words[head] = value;
                  count++;
               end else begin
                  words[(head + count) % dq_pkg::DEPTH] = value;
                  count++;
               end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
               if (count != 0) begin
                  if (op == dq_pkg::OP_POP_FRONT) begin
                     r.popped_value = words[head];
                     head = (head + 1) % dq_pkg::DEPTH;
                  end else begin
                     r.popped_value = words[(head + count - 1) % dq_pkg::DEPTH];
                  end
                  count--;
                  r.popped_valid = 1'b1;
               end else begin
                  empty_pops++;
               end
            end
            default: begin
               // report, and the unused codes behave the same
            end
         endcase
         if (count != 0) begin
            r.front_value = words[head];
            r.back_value = words[(head + count - 1) % dq_pkg::DEPTH];
         end
         r.entry_count = dq_pkg::COUNT_OUT_W'(count);
         r.is_empty = (count == 0);
         if (count > peak) peak = count;
         pending_results = {pending_results, r};
      endfunction

      function void match_response(deque_result_type got);
         deque_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response word at %0t", $realtime);
            return;
         end
         want = pending_results[0];
         pending_results.delete(0);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch on response %0d at %0t", results_seen, $realtime);
               $display("  expected pop %0d/%0b count %0d empty %0b front %0d back %0d ovf %0b",
                        want.popped_value, want.popped_valid, want.entry_count,
                        want.is_empty, want.front_value, want.back_value, want.overflow);
               $display("  actual   pop %0d/%0b count %0d empty %0b front %0d back %0d ovf %0b",
                        got.popped_value, got.popped_valid, got.entry_count,
                        got.is_empty, got.front_value, got.back_value, got.overflow);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   bit   no_idle;
   bit   hold_pending;
   int   words_sent;

   dq_req_if req_ch ();
   dq_rsp_if rsp_ch ();

   deque_tracker_type tracker;

   double_ended_queue u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(5);
   endfunction

   function automatic logic signed [dq_pkg::WORD_W-1:0] draw_value();
      logic signed [dq_pkg::WORD_W-1:0] v;
      case ($urandom_range(15))
         0: v = 32'sh7fffffff;
         1: v = 32'sh80000000;
         2: v = '0;
         3: v = -32'sd1;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic logic [dq_pkg::OP_W-1:0] draw_op(int push_w, int pop_w, int other_w);
      int r;
      r = $urandom_range(push_w + pop_w + other_w - 1);
      if (r < push_w)
         return $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
      if (r < push_w + pop_w)
         return $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
      // report or one of the unused codes
      return dq_pkg::OP_W'($urandom_range(7, 4));
   endfunction

   task automatic send_word(logic [dq_pkg::OP_W-1:0] op,
                            logic signed [dq_pkg::WORD_W-1:0] value);
      int gap;
      gap = draw_gap();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.push_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.apply_op(op, value);
      words_sent++;
   endtask

   task automatic send_random(int n, int push_w, int pop_w, int other_w);
      repeat (n) send_word(draw_op(push_w, pop_w, other_w), draw_value());
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin : response_side
      int stall;
      deque_result_type got;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_pending) begin
            stall = HOLD_CYCLES;
            hold_pending = 1'b0;
         end else begin
            stall = draw_gap();
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got.popped_value = rsp_ch.popped_value;
         got.popped_valid = rsp_ch.popped_valid;
         got.entry_count = rsp_ch.entry_count;
         got.is_empty = rsp_ch.is_empty;
         got.front_value = rsp_ch.front_value;
         got.back_value = rsp_ch.back_value;
         got.overflow = rsp_ch.overflow;
         tracker.match_response(got);
      end
   end

   initial begin : request_side
      int n;
      tracker = new();
      no_idle = 1'b0;
      hold_pending = 1'b0;
      words_sent = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = dq_pkg::OP_REPORT;
      req_ch.push_value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store, unused codes, extremes at both ends
      send_word(dq_pkg::OP_REPORT, 32'sd0);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);
      send_word(dq_pkg::OP_POP_BACK, 32'sd0);
      send_word(3'd5, 32'sh7fffffff);
      send_word(3'd6, 32'sh80000000);
      send_word(3'd7, -32'sd1);
      send_word(dq_pkg::OP_PUSH_BACK, 32'sh7fffffff);
      send_word(dq_pkg::OP_PUSH_FRONT, 32'sh80000000);
      send_word(dq_pkg::OP_REPORT, 32'sd0);
      send_word(dq_pkg::OP_POP_BACK, 32'sd0);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);
      send_word(dq_pkg::OP_PUSH_FRONT, -32'sd1);
      send_word(dq_pkg::OP_PUSH_BACK, 32'sd0);
      send_word(dq_pkg::OP_PUSH_BACK, 32'sd1);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);
      send_word(dq_pkg::OP_POP_BACK, 32'sd0);
      send_word(dq_pkg::OP_POP_BACK, 32'sd0);
      send_word(dq_pkg::OP_PUSH_FRONT, 32'sh55555555);
      send_word(dq_pkg::OP_PUSH_BACK, 32'shaaaaaaaa);
      send_word(dq_pkg::OP_POP_BACK, 32'sd0);
      send_word(dq_pkg::OP_POP_BACK, 32'sd0);
      send_word(dq_pkg::OP_POP_FRONT, 32'sd0);

      // back-to-back requests against a receiver that holds off
      no_idle = 1'b1;
      hold_pending = 1'b1;
      send_random(40, 40, 45, 15);
      no_idle = 1'b0;
      send_random(160, 40, 45, 15);

      // fill to capacity, alternating idle and busy stretches
      n = 0;
      while (tracker.count < dq_pkg::DEPTH) begin
         if (n % 150 == 0) no_idle = $urandom_range(1);
         send_word(draw_op(96, 2, 2), draw_value());
         n++;
      end
      no_idle = 1'b0;

      // pushes against a full store
      send_random(25, 80, 5, 15);

      // drain with a mixed stream
      send_random(200, 25, 60, 15);
      no_idle = 1'b1;
      send_random(100, 25, 60, 15);
      no_idle = 1'b0;
      send_random(150, 25, 60, 15);

      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d request words, %0d responses, peak occupancy %0d of %0d",
               words_sent, tracker.results_seen, tracker.peak, dq_pkg::DEPTH);
      $display("%0d dropped pushes, %0d pops on empty, %0d mismatches",
               tracker.overflows, tracker.empty_pops, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
